// File: src/utf8_to_utf16_latin1_fallback_top_assert.svh
// Assertion macros for the UTF-8 to UTF-16 converter.
`ifndef UTF8_TO_UTF16_LATIN1_FALLBACK_TOP_ASSERT_SVH
`define UTF8_TO_UTF16_LATIN1_FALLBACK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// condition must hold at every edge out of reset
`define U8U16_ASSERT(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("u8u16 check failed");
// consequent must hold in the cycle after the antecedent
`define U8U16_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("u8u16 check failed");
`else
`define U8U16_ASSERT(label, cond)
`define U8U16_ASSERT_NEXT(label, pre, post)
`endif
`endif

// File: src/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 converter.
`timescale 1ns / 1ps
package u8u16_pkg;

  localparam int unsigned MaxUnits = 4;

  localparam logic [7:0]  ContMask   = 8'b1100_0000;
  localparam logic [7:0]  ContTag    = 8'b1000_0000;
  localparam logic [7:0]  Lead3Min   = 8'b1110_0000;
  localparam logic [7:0]  Lead4Min   = 8'b1111_0000;
  localparam logic [7:0]  LeadLimit  = 8'b1111_1000;
  localparam logic [20:0] Min2Byte   = 21'h80;
  localparam logic [20:0] Min3Byte   = 21'h800;
  localparam logic [20:0] Min4Byte   = 21'h10000;
  localparam logic [15:0] HiSurr     = 16'hD800;
  localparam logic [15:0] LoSurr     = 16'hDC00;
  localparam logic [9:0]  LoMask     = 10'h3FF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_unit;
    logic        run_last;
    logic        string_done;
  } out_item_t;

  // held partial sequence
  typedef struct packed {
    logic [7:0]      lead;
    logic [1:0][7:0] tail;
    logic [1:0]      count;
  } held_t;

  // units caused by one byte
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [2:0]                cnt;
    logic                      eos;
  } bundle_t;

endpackage

// File: src/u8u16_decode.sv
// Decode of one byte against the held sequence into a group of units.
`timescale 1ns / 1ps
module u8u16_decode (
  input  u8u16_pkg::in_item_t item_i,
  input  u8u16_pkg::held_t    held_i,
  output u8u16_pkg::held_t    held_o,
  output u8u16_pkg::bundle_t  bundle_o
);
  import u8u16_pkg::*;

  logic [7:0]  b;
  logic        eos;
  logic        cont;
  logic [1:0]  hc;
  logic [1:0]  need_hc;
  logic [20:0] c2, c3, c4, cv, minv, v;
  logic        complete;
  logic [1:0]  flush_n;
  logic        emit;
  logic        pair;

  always_comb begin
    b    = item_i.in_byte;
    eos  = item_i.end_of_string;
    cont = (b & ContMask) == ContTag;
    hc   = held_i.count;

    if (held_i.lead < Lead3Min) begin
      need_hc = 2'd1;
    end else if (held_i.lead < Lead4Min) begin
      need_hc = 2'd2;
    end else begin
      need_hc = 2'd3;
    end
    complete = (hc == need_hc);

    c2 = {10'd0, held_i.lead[4:0], b[5:0]};
    c3 = {5'd0, held_i.lead[3:0], held_i.tail[0][5:0], b[5:0]};
    c4 = {held_i.lead[2:0], held_i.tail[0][5:0], held_i.tail[1][5:0], b[5:0]};
    case (need_hc)
      2'd1: begin
        cv = c2;
        minv = Min2Byte;
      end
      2'd2: begin
        cv = c3;
        minv = Min3Byte;
      end
      default: begin
        cv = c4;
        minv = Min4Byte;
      end
    endcase
    v = cv - Min4Byte;

    held_o  = held_i;
    flush_n = 2'd0;
    emit    = 1'b0;
    pair    = 1'b0;

    if (hc != 2'd0 && cont) begin
      if (complete) begin
        held_o.count = 2'd0;
        if (cv < minv) begin
          flush_n = hc;
          emit    = 1'b1;
        end else if (cv >= Min4Byte) begin
          pair = 1'b1;
        end else begin
          emit = 1'b1;
        end
      end else if (eos) begin
        held_o.count = 2'd0;
        flush_n      = hc;
        emit         = 1'b1;
      end else begin
        // store tail; count is 1 or 2 here
        held_o.tail[hc[1]] = b;
        held_o.count       = hc + 2'd1;
      end
    end else begin
      flush_n      = hc;
      held_o.count = 2'd0;
      if (b >= ContMask && b < LeadLimit && !eos) begin
        held_o.lead  = b;
        held_o.count = 2'd1;
      end else begin
        emit = 1'b1;
      end
    end

    bundle_o.eos      = eos;
    bundle_o.units[0] = {8'd0, held_i.lead};
    bundle_o.units[1] = {8'd0, held_i.tail[0]};
    bundle_o.units[2] = {8'd0, held_i.tail[1]};
    bundle_o.units[3] = {8'd0, b};
    if (pair) begin
      bundle_o.units[0] = HiSurr + {5'd0, v[20:10]};
      bundle_o.units[1] = LoSurr | {6'd0, v[9:0] & LoMask};
      bundle_o.cnt      = 3'd2;
    end else begin
      if (emit) begin
        bundle_o.units[flush_n] = (hc != 2'd0 && cont && complete && !(cv < minv))
                                  ? cv[15:0] : {8'd0, b};
      end
      bundle_o.cnt = {1'b0, flush_n} + {2'd0, emit};
    end
  end

endmodule

// File: src/u8u16_outbuf.sv
// Result register that hands out a group of units one word at a time.
`timescale 1ns / 1ps
module u8u16_outbuf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  u8u16_pkg::bundle_t    bundle_i,
  output logic                  free_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output u8u16_pkg::out_item_t  out_data_o
);
  import u8u16_pkg::*;

  logic [MaxUnits-1:0][15:0] units_q;
  logic [1:0]                idx_q, last_q;
  logic                      eos_q;
  logic                      valid_q;
  logic                      at_last;
  logic                      take;

  assign at_last = idx_q == last_q;
  assign take    = valid_q && !out_stall_i;
  assign free_o  = !valid_q || (take && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
      last_q  <= 2'd0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= 2'd0;
      last_q  <= 2'(bundle_i.cnt - 3'd1);
    end else if (take) begin
      // advance, or drop the group after its last word
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      units_q <= bundle_i.units;
      eos_q   <= bundle_i.eos;
    end
  end

  assign out_valid_o            = valid_q;
  assign out_data_o.out_unit    = units_q[idx_q];
  assign out_data_o.run_last    = at_last;
  assign out_data_o.string_done = at_last && eos_q;

endmodule

// File: src/utf8_to_utf16_latin1_fallback_top.sv
// Top level of the UTF-8 to UTF-16 converter with Latin-1 fallback.
//
//   channel  direction  handshake                 word
//   in       input      in_valid_i / in_stall_o   in_item_t (byte, end flag)
//   out      output     out_valid_o / out_stall_i out_item_t (unit, flags)
//
// A byte goes to the input register, is decoded there combinationally and its
// 0 to 4 units enter the result register, which sends one unit per cycle unless
// out_stall_i is high. Unstalled, sustained rate is one byte per cycle while each
// byte gives at most one unit; a byte that gives more units holds the result register until its last unit is sent.
// Reset clears the held sequence and both registers' valid flags.
// in_stall_o rises only while a decoded byte waits for the result register.
`timescale 1ns / 1ps
`include "utf8_to_utf16_latin1_fallback_top_assert.svh"
module utf8_to_utf16_latin1_fallback_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  u8u16_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output u8u16_pkg::out_item_t out_data_o
);
  import u8u16_pkg::*;

  in_item_t        in_q;
  logic            in_valid_q;
  logic [7:0]      lead_q;
  logic [1:0][7:0] tail_q;
  logic [1:0]      count_q;
  held_t           held_q, held_d;
  bundle_t         bundle;
  logic            buf_free;
  logic            consume;
  logic            load;
  logic            in_take;

  assign held_q = {lead_q, tail_q, count_q};

  u8u16_decode u_decode (
    .item_i   (in_q),
    .held_i   (held_q),
    .held_o   (held_d),
    .bundle_o (bundle)
  );

  // a byte with no units never waits on the result register
  assign consume    = in_valid_q && (bundle.cnt == 3'd0 || buf_free);
  assign load       = consume && bundle.cnt != 3'd0;
  assign in_stall_o = in_valid_q && !consume;
  assign in_take    = in_valid_i && !in_stall_o;

  u8u16_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .bundle_i    (bundle),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      lead_q     <= 8'd0;
      count_q    <= 2'd0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (consume) begin
        in_valid_q <= 1'b0;
      end
      if (consume) begin
        lead_q  <= held_d.lead;
        count_q <= held_d.count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (consume) begin
      tail_q <= held_d.tail;
    end
  end

  `U8U16_ASSERT(a_stall_needs_word, !in_stall_o || in_valid_q)
  `U8U16_ASSERT(a_three_held_is_4byte, held_q.count != 2'd3 || held_q.lead >= Lead4Min)
  `U8U16_ASSERT_NEXT(a_eos_clears_held, consume && in_q.end_of_string, held_q.count == 2'd0)
  `U8U16_ASSERT(a_load_only_when_free, !load || buf_free)

endmodule

// File: test/utf16_unit_checker.sv
// Checker that predicts the converter's UTF-16 words and compares them with the output channel.
`timescale 1ns / 1ps
module utf16_unit_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  u8u16_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  u8u16_pkg::out_item_t out_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import u8u16_pkg::*;

  localparam logic [7:0] Lead2Min    = 8'hC0;
  localparam int         ReportLimit = 40;

  // held partial sequence
  logic [7:0] held_lead;
  logic [7:0] held_tail [2];
  logic [1:0] held_count;

  logic [15:0] step_units [MaxUnits];
  int          step_n;
  out_item_t   expected_units [$];
  int          errors = 0;

  function automatic void add_unit(input logic [15:0] unit);
    step_units[step_n] = unit;
    step_n++;
  endfunction

  // emit every held byte alone, lead first
  function automatic void flush_held();
    if (held_count != 2'd0) begin
      add_unit({8'd0, held_lead});
      if (held_count >= 2'd2) add_unit({8'd0, held_tail[0]});
      if (held_count == 2'd3) add_unit({8'd0, held_tail[1]});
      held_count = 2'd0;
    end
  endfunction

  function automatic void decode_utf8_byte(input in_item_t item);
    logic [7:0]  b;
    logic        eos;
    logic        cont;
    logic        taken;
    int          need;
    logic [20:0] cp;
    logic [20:0] floor_cp;
    logic [20:0] offset;
    out_item_t   w;
    b      = item.in_byte;
    eos    = item.end_of_string;
    cont   = (b & ContMask) == ContTag;
    taken  = 1'b0;
    step_n = 0;
    if (held_count != 2'd0) begin
      if (held_lead < Lead3Min) need = 2;
      else if (held_lead < Lead4Min) need = 3;
      else need = 4;
      if (cont) begin
        taken = 1'b1;
        if (int'(held_count) + 1 == need) begin
          if (need == 2) begin
            cp       = {10'd0, held_lead[4:0], b[5:0]};
            floor_cp = Min2Byte;
          end else if (need == 3) begin
            cp       = {5'd0, held_lead[3:0], held_tail[0][5:0], b[5:0]};
            floor_cp = Min3Byte;
          end else begin
            cp       = {held_lead[2:0], held_tail[0][5:0], held_tail[1][5:0], b[5:0]};
            floor_cp = Min4Byte;
          end
          if (cp < floor_cp) begin
            // overlong: every byte goes out alone
            flush_held();
            add_unit({8'd0, b});
          end else if (cp >= Min4Byte) begin
            offset     = cp - Min4Byte;
            held_count = 2'd0;
            add_unit(HiSurr + {5'd0, offset[20:10]});
            add_unit(LoSurr + {6'd0, offset[9:0] & LoMask});
          end else begin
            held_count = 2'd0;
            add_unit(cp[15:0]);
          end
        end else if (eos) begin
          // cut off by the end of the string
          flush_held();
          add_unit({8'd0, b});
        end else begin
          if (held_count == 2'd1) held_tail[0] = b;
          else held_tail[1] = b;
          held_count = held_count + 2'd1;
        end
      end else begin
        // broken sequence: send out what is held, then decode this byte afresh
        flush_held();
      end
    end
    if (!taken) begin
      if (b >= Lead2Min && b < LeadLimit && !eos) begin
        held_lead  = b;
        held_count = 2'd1;
      end else begin
        add_unit({8'd0, b});
      end
    end
    for (int i = 0; i < step_n; i++) begin
      w.out_unit    = step_units[i];
      w.run_last    = (i == step_n - 1);
      w.string_done = (i == step_n - 1) && eos;
      expected_units.push_back(w);
    end
  endfunction

  function automatic void check_unit(input out_item_t got);
    out_item_t want;
    if (expected_units.size() == 0) begin
      if (errors < ReportLimit) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
      end
      errors++;
    end else begin
      want = expected_units.pop_front();
      if (want !== got) begin
        if (errors < ReportLimit) begin
          if (want.out_unit !== got.out_unit)
            $display("%0t: out_unit expected %h, actual %h", $time, want.out_unit,
                     got.out_unit);
          if (want.run_last !== got.run_last)
            $display("%0t: run_last expected %b, actual %b", $time, want.run_last,
                     got.run_last);
          if (want.string_done !== got.string_done)
            $display("%0t: string_done expected %b, actual %b", $time,
                     want.string_done, got.string_done);
        end
        errors++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_lead    = '0;
      held_tail[0] = '0;
      held_tail[1] = '0;
      held_count   = '0;
      expected_units.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // queue this edge's byte first, in case its word leaves at once
      if (in_valid_i && !in_stall_i) decode_utf8_byte(in_data_i);
      if (out_valid_i && !out_stall_i) check_unit(out_data_i);
      fail_count_o <= errors;
      pending_o    <= expected_units.size();
    end
  end

endmodule

// File: test/utf8_to_utf16_latin1_fallback_top_tb.sv
// Testbench top: feeds UTF-8 strings to the converter and reports the verdict.
`timescale 1ns / 1ps
module utf8_to_utf16_latin1_fallback_top_tb;
  import u8u16_pkg::*;

  localparam int TotalBytes  = 470;
  localparam int CalmBytes   = 60;
  localparam int CycleLimit  = 200000;
  localparam int DrainCycles = 16;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  int         fail_count;
  int         pending_units;
  int         cycle_count = 0;
  int         bytes_sent;
  int         gap_pct;
  int         stall_pct;
  logic [7:0] string_bytes [$];

  utf8_to_utf16_latin1_fallback_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  utf16_unit_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fail_count),
    .pending_o   (pending_units)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // stall the output side in bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= {b, eos};
    // hold the word until it is taken
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_string();
    for (int i = 0; i < string_bytes.size(); i++)
      send_byte(string_bytes[i], i == string_bytes.size() - 1);
    string_bytes.delete();
  endtask

  function automatic void add_seq(input logic [20:0] cp, input int len);
    case (len)
      1: string_bytes.push_back({1'b0, cp[6:0]});
      2: begin
        string_bytes.push_back({3'b110, cp[10:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      3: begin
        string_bytes.push_back({4'b1110, cp[15:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
      default: begin
        string_bytes.push_back({5'b11110, cp[20:18]});
        string_bytes.push_back({2'b10, cp[17:12]});
        string_bytes.push_back({2'b10, cp[11:6]});
        string_bytes.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void add_token();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    len  = $urandom_range(2, 4);
    if (pick < 25) add_seq(21'($urandom_range(0, 'h7F)), 1);
    else if (pick < 43) add_seq(21'($urandom_range('h80, 'h7FF)), 2);
    else if (pick < 60) add_seq(21'($urandom_range('h800, 'hFFFF)), 3);
    else if (pick < 76) add_seq(21'($urandom_range('h10000, 'h1FFFFF)), 4);
    else if (pick < 84) begin
      // overlong encodings
      if (len == 2) add_seq(21'($urandom_range(0, 'h7F)), 2);
      else if (len == 3) add_seq(21'($urandom_range(0, 'h7FF)), 3);
      else add_seq(21'($urandom_range(0, 'hFFFF)), 4);
    end else if (pick < 92) begin
      // cut a sequence short so the next byte breaks it
      add_seq(21'($urandom), len);
      repeat ($urandom_range(1, len - 1)) void'(string_bytes.pop_back());
    end else begin
      string_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    bytes_sent = 0;
    gap_pct    = 20;
    stall_pct  = 20;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ASCII ends, stray continuations, bytes past any lead
    string_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF};
    send_string();
    // two-byte, overlong, broken then three-byte, pair, pair past range, truncated
    string_bytes = '{8'hC3, 8'hA9, 8'hC1, 8'hBF, 8'hC3, 8'hE2, 8'h82, 8'hAC,
                     8'hF0, 8'h9F, 8'h98, 8'h80, 8'hF7, 8'hBF, 8'hBF, 8'hBF,
                     8'hE2, 8'h82};
    send_string();
    // lead on the last byte
    string_bytes = '{8'hC3};
    send_string();

    while (bytes_sent < TotalBytes) begin
      if (bytes_sent >= TotalBytes - CalmBytes) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 10; stall_pct = 10; end
          2: begin gap_pct = 40; stall_pct = 20; end
          default: begin gap_pct = 5; stall_pct = 50; end
        endcase
      end
      repeat ($urandom_range(1, 8)) add_token();
      send_string();
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending_units != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_units == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/u8u16_pkg.sv
src/u8u16_decode.sv
src/u8u16_outbuf.sv
src/utf8_to_utf16_latin1_fallback_top.sv
test/utf16_unit_checker.sv
test/utf8_to_utf16_latin1_fallback_top_tb.sv
